// ===== hdl/kaa_pkg.sv =====
// Shared constants and codes for the k-means assignment and accumulation block.
package kaa_pkg;

  localparam int unsigned FEAT_W  = 16;
  localparam int unsigned DIFF_W  = FEAT_W + 1;
  localparam int unsigned SQ_W    = 2 * DIFF_W;
  localparam int unsigned DIST_W  = 48;
  localparam int unsigned SUM_W   = 40;
  localparam int unsigned COUNT_W = 16;
  localparam int unsigned CL_W    = 4;
  localparam int unsigned EL_W    = 10;
  localparam int unsigned CCNT_W  = 5;
  localparam int unsigned FCNT_W  = 11;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 11;

  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_SAMPLE = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;
  localparam logic [1:0] OP_CLEAR  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_CLUSTER_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FEATURE_COUNT = 2'd1;

endpackage

// ===== hdl/kaa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module kaa_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== hdl/kaa_cell.sv =====
// One distance accumulator cell of the rotating accumulator chain.
module kaa_cell (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       clr_i,
  input  logic                       shift_i,
  input  logic [kaa_pkg::DIST_W-1:0] din_i,
  output logic [kaa_pkg::DIST_W-1:0] q_o
);
  import kaa_pkg::*;

  logic [DIST_W-1:0] acc_q, acc_d;

  always_comb begin
    acc_d = acc_q;
    if (clr_i) begin
      acc_d = '0;
    end else if (shift_i) begin
      acc_d = din_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  assign q_o = acc_q;

endmodule

// ===== hdl/kmeans_assign_accumulate.sv =====
// Top level: k-means assignment step with rotating distance chain and sum store.
//
//  channel   ports                                   direction  handshake
//  command   start, busy, operation/cluster/element/value_i   in   start && !busy
//  result    strobe_o, sum_value/member_count/read_*_o  out      strobe_o, one cycle
//  config    cfg_valid_i, cfg_ready_o, cfg_index_i, cfg_data_i  in  valid && ready
//
// Load and read do not raise busy; a read's word appears on the cycle after accept.
// A sample feature is paced by the one-read-per-cycle center RAM feeding the
// shared subtract-square unit and the accumulator ring. The last feature adds
// a minimum search over the ring and a sum RAM update for every feature.
// After reset, and on every clear, the sum RAM is zeroed while busy is high.
// Results cannot be stalled.
module kmeans_assign_accumulate #(
  parameter int unsigned MAX_CLUSTERS = 16,
  parameter int unsigned MAX_FEATURES = 1024
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic [1:0]                      operation_i,
  input  logic [kaa_pkg::CL_W-1:0]        cluster_i,
  input  logic [kaa_pkg::EL_W-1:0]        element_i,
  input  logic signed [kaa_pkg::FEAT_W-1:0] value_i,
  output logic                            strobe_o,
  output logic signed [kaa_pkg::SUM_W-1:0] sum_value_o,
  output logic [kaa_pkg::COUNT_W-1:0]     member_count_o,
  output logic [kaa_pkg::CL_W-1:0]        read_cluster_o,
  output logic [kaa_pkg::EL_W-1:0]        read_element_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [kaa_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [kaa_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import kaa_pkg::*;

  localparam int unsigned DEPTH = MAX_CLUSTERS * MAX_FEATURES;
  localparam int unsigned AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;
  localparam int unsigned FAW   = MAX_FEATURES > 1 ? $clog2(MAX_FEATURES) : 1;
  localparam int unsigned CW    = MAX_CLUSTERS > 1 ? $clog2(MAX_CLUSTERS) : 1;
  localparam int unsigned NKW   = $clog2(MAX_CLUSTERS + 1);
  localparam int unsigned NFW   = $clog2(MAX_FEATURES + 1);

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_DIST   = 3'd2;
  localparam logic [2:0] ST_ARGMIN = 3'd3;
  localparam logic [2:0] ST_ADD    = 3'd4;

  logic [2:0] state_q, state_d;

  // configuration
  logic [CCNT_W-1:0] ccnt_q;
  logic [FCNT_W-1:0] fcnt_q;
  logic [NKW-1:0] nk;
  logic [NFW-1:0] nf;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ccnt_q <= CCNT_W'(1);
      fcnt_q <= FCNT_W'(1);
    end else if (cfg_valid_i) begin
      if (cfg_index_i == REG_CLUSTER_COUNT) begin
        ccnt_q <= cfg_data_i[CCNT_W-1:0];
      end else if (cfg_index_i == REG_FEATURE_COUNT) begin
        fcnt_q <= cfg_data_i[FCNT_W-1:0];
      end
    end
  end

  always_comb begin
    if (ccnt_q == '0) begin
      nk = NKW'(1);
    end else if (ccnt_q > MAX_CLUSTERS) begin
      nk = NKW'(MAX_CLUSTERS);
    end else begin
      nk = NKW'(ccnt_q);
    end
    if (fcnt_q == '0) begin
      nf = NFW'(1);
    end else if (fcnt_q > MAX_FEATURES) begin
      nf = NFW'(MAX_FEATURES);
    end else begin
      nf = NFW'(fcnt_q);
    end
  end

  // command decode
  logic accept, in_range, is_load, is_sample, is_read, is_clear;
  logic [AW-1:0] cmd_addr;

  assign busy      = (state_q != ST_IDLE);
  assign accept    = start && !busy;
  assign in_range  = (cluster_i < MAX_CLUSTERS) && (element_i < MAX_FEATURES);
  assign is_load   = accept && (operation_i == OP_LOAD) && in_range;
  assign is_sample = accept && (operation_i == OP_SAMPLE) && (element_i < nf);
  assign is_read   = accept && (operation_i == OP_READ);
  assign is_clear  = accept && (operation_i == OP_CLEAR);
  assign cmd_addr  = AW'(cluster_i * MAX_FEATURES + element_i);

  // sample item registers
  logic [EL_W-1:0]          el_q;
  logic signed [FEAT_W-1:0] val_q;
  logic                     last_q;

  always_ff @(posedge clk_i) begin
    if (is_sample) begin
      el_q   <= element_i;
      val_q  <= value_i;
      last_q <= (element_i == nf - 1'b1);
    end
  end

  // center store
  logic [FEAT_W-1:0] center_rdata;
  logic [AW-1:0]     center_raddr;
  logic              iss_act_q, iss_act_d;
  logic [CW-1:0]     iss_k_q, iss_k_d;

  assign center_raddr = AW'(iss_k_q * MAX_FEATURES + el_q);

  kaa_ram #(.WIDTH(FEAT_W), .DEPTH(DEPTH)) u_center (
    .clk_i   (clk_i),
    .we_i    (is_load),
    .waddr_i (cmd_addr),
    .wdata_i (value_i),
    .raddr_i (center_raddr),
    .rdata_o (center_rdata)
  );

  // sample buffer
  logic [FEAT_W-1:0] sample_rdata;
  logic [NFW-1:0]    add_e_q, add_e_d;

  kaa_ram #(.WIDTH(FEAT_W), .DEPTH(MAX_FEATURES)) u_sample (
    .clk_i   (clk_i),
    .we_i    (is_sample),
    .waddr_i (FAW'(element_i)),
    .wdata_i (value_i),
    .raddr_i (FAW'(add_e_q)),
    .rdata_o (sample_rdata)
  );

  // subtract-square pipeline
  logic                     v1_q, v2_q, v3_q;
  logic [CW-1:0]            k1_q, k2_q, k3_q;
  logic signed [DIFF_W-1:0] diff_q;
  logic [SQ_W-1:0]          sq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= iss_act_q;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    k1_q   <= iss_k_q;
    k2_q   <= k1_q;
    k3_q   <= k2_q;
    diff_q <= DIFF_W'(val_q) - DIFF_W'($signed(center_rdata));
    sq_q   <= $unsigned(SQ_W'(diff_q) * SQ_W'(diff_q));
  end

  // accumulator ring: cell 0 is the head, the ring rotates toward it
  logic [DIST_W-1:0] cell_q  [MAX_CLUSTERS];
  logic [DIST_W-1:0] cell_din[MAX_CLUSTERS];
  logic [DIST_W-1:0] head_new;
  logic              ring_shift, ring_clr;
  logic [CW-1:0]     am_k_q, am_k_d;

  assign ring_clr   = is_sample && (element_i == '0);
  assign ring_shift = v3_q || (state_q == ST_ARGMIN);

  always_comb begin
    head_new = cell_q[0];
    if (v3_q && (NKW'(k3_q) < nk)) begin
      head_new = cell_q[0] + DIST_W'(sq_q);
    end
  end

  for (genvar i = 0; i < MAX_CLUSTERS; i++) begin : g_ring
    if (i == MAX_CLUSTERS - 1) begin : g_tail
      assign cell_din[i] = head_new;
    end else begin : g_mid
      assign cell_din[i] = cell_q[i+1];
    end
    kaa_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .clr_i   (ring_clr),
      .shift_i (ring_shift),
      .din_i   (cell_din[i]),
      .q_o     (cell_q[i])
    );
  end

  // minimum search over the rotating ring
  logic [DIST_W-1:0] best_dist_q;
  logic [CW-1:0]     best_q;

  always_ff @(posedge clk_i) begin
    if (state_q == ST_ARGMIN) begin
      if (am_k_q == '0) begin
        best_dist_q <= cell_q[0];
        best_q      <= '0;
      end else if ((NKW'(am_k_q) < nk) && (cell_q[0] < best_dist_q)) begin
        best_dist_q <= cell_q[0];
        best_q      <= am_k_q;
      end
    end
  end

  // sum store
  logic [SUM_W-1:0] sum_rdata, sum_wdata;
  logic [AW-1:0]    sum_raddr, sum_waddr;
  logic             sum_we;
  logic [AW-1:0]    clr_a_q, clr_a_d;
  logic             pv_q;
  logic [AW-1:0]    pa_q;
  logic             add_iss;

  assign add_iss = (state_q == ST_ADD) && (add_e_q < nf);
  assign sum_raddr = (state_q == ST_ADD) ? AW'(best_q * MAX_FEATURES + add_e_q) : cmd_addr;

  always_comb begin
    sum_we    = 1'b0;
    sum_waddr = pa_q;
    sum_wdata = sum_rdata + {{(SUM_W-FEAT_W){sample_rdata[FEAT_W-1]}}, sample_rdata};
    if (state_q == ST_CLEAR) begin
      sum_we    = 1'b1;
      sum_waddr = clr_a_q;
      sum_wdata = '0;
    end else if (pv_q) begin
      sum_we = 1'b1;
    end
  end

  kaa_ram #(.WIDTH(SUM_W), .DEPTH(DEPTH)) u_sum (
    .clk_i   (clk_i),
    .we_i    (sum_we),
    .waddr_i (sum_waddr),
    .wdata_i (sum_wdata),
    .raddr_i (sum_raddr),
    .rdata_o (sum_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= 1'b0;
    end else begin
      pv_q <= add_iss;
    end
  end

  always_ff @(posedge clk_i) begin
    pa_q <= sum_raddr;
  end

  // member counts
  logic [COUNT_W-1:0] count_q [MAX_CLUSTERS];
  logic               add_done;

  assign add_done = (state_q == ST_ADD) && !add_iss && !pv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_CLUSTERS; i++) begin
        count_q[i] <= '0;
      end
    end else if (is_clear) begin
      for (int i = 0; i < MAX_CLUSTERS; i++) begin
        count_q[i] <= '0;
      end
    end else if (add_done && (count_q[best_q] != '1)) begin
      count_q[best_q] <= count_q[best_q] + 1'b1;
    end
  end

  // read result
  logic               rd_pend_q, rd_ok_q;
  logic [COUNT_W-1:0] rd_count_q;
  logic [CL_W-1:0]    rd_cl_q;
  logic [EL_W-1:0]    rd_el_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_pend_q <= 1'b0;
    end else begin
      rd_pend_q <= is_read;
    end
  end

  always_ff @(posedge clk_i) begin
    if (is_read) begin
      rd_ok_q    <= in_range;
      rd_count_q <= count_q[CW'(cluster_i)];
      rd_cl_q    <= cluster_i;
      rd_el_q    <= element_i;
    end
  end

  assign strobe_o       = rd_pend_q;
  assign sum_value_o    = rd_ok_q ? $signed(sum_rdata) : '0;
  assign member_count_o = rd_ok_q ? rd_count_q : '0;
  assign read_cluster_o = rd_cl_q;
  assign read_element_o = rd_el_q;

  // sequencer
  always_comb begin
    state_d   = state_q;
    iss_act_d = iss_act_q;
    iss_k_d   = iss_k_q;
    am_k_d    = am_k_q;
    add_e_d   = add_e_q;
    clr_a_d   = clr_a_q;
    unique case (state_q)
      ST_CLEAR: begin
        clr_a_d = clr_a_q + 1'b1;
        if (clr_a_q == AW'(DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (is_sample) begin
          state_d   = ST_DIST;
          iss_act_d = 1'b1;
          iss_k_d   = '0;
        end else if (is_clear) begin
          state_d = ST_CLEAR;
          clr_a_d = '0;
        end
      end
      ST_DIST: begin
        if (iss_act_q) begin
          iss_k_d = iss_k_q + 1'b1;
          if (iss_k_q == CW'(MAX_CLUSTERS - 1)) begin
            iss_act_d = 1'b0;
          end
        end
        if (v3_q && (k3_q == CW'(MAX_CLUSTERS - 1))) begin
          if (last_q) begin
            state_d = ST_ARGMIN;
            am_k_d  = '0;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_ARGMIN: begin
        am_k_d = am_k_q + 1'b1;
        if (am_k_q == CW'(MAX_CLUSTERS - 1)) begin
          state_d = ST_ADD;
          add_e_d = '0;
        end
      end
      ST_ADD: begin
        if (add_iss) begin
          add_e_d = add_e_q + 1'b1;
        end
        if (add_done) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      iss_act_q <= 1'b0;
      iss_k_q   <= '0;
      am_k_q    <= '0;
      add_e_q   <= '0;
      clr_a_q   <= '0;
    end else begin
      state_q   <= state_d;
      iss_act_q <= iss_act_d;
      iss_k_q   <= iss_k_d;
      am_k_q    <= am_k_d;
      add_e_q   <= add_e_d;
      clr_a_q   <= clr_a_d;
    end
  end

endmodule
